FILE: src/tts_pkg.sv
// shared types and codes for the task table round robin scheduler
// no dependencies; imported by tts_slot_mem and task_table_round_robin_scheduler
`default_nettype none

package tts_pkg;

  // fixed field widths of the item, result and configuration channels, and of the tick counter
  localparam int ACTION_W   = 3;
  localparam int AMOUNT_W   = 8;
  localparam int TASKNUM_W  = 8;
  localparam int STATUS_W   = 3;
  localparam int AFFECT_W   = 5;
  localparam int RSLOT_W    = 4;
  localparam int USED_W     = 5;
  localparam int TICK_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // slot state codes as stored in the slot memory
  typedef logic [1:0] slot_state_t;
  localparam slot_state_t SS_READY      = 2'd0;
  localparam slot_state_t SS_RUNNING    = 2'd1;
  localparam slot_state_t SS_SUSPENDED  = 2'd2;
  localparam slot_state_t SS_TERMINATED = 2'd3;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_CREATE     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_KILL       = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_INTERRUPT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_RESUME_ONE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RESUME_ALL = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_TICK       = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_FCFS       = 3'd6;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_TERMINATED = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NONE_SUSP  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CREATE,
    ST_SCAN,
    ST_DONE
  } sched_state_t;

  // what a slot scan looks for and what it does on a hit
  typedef enum logic [2:0] {
    SK_FCFS,
    SK_RR,
    SK_RESUME_ALL,
    SK_KILL,
    SK_RESUME_ONE
  } scan_kind_t;

endpackage

`default_nettype wire

FILE: src/tts_slot_mem.sv
// slot state memory: one write port, one read port with registered data
// depends on tts_pkg for the slot state type
`default_nettype none

module tts_slot_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [AW-1:0]            waddr,
  input  tts_pkg::slot_state_t     wdata,
  input  wire                      re,
  input  wire  [AW-1:0]            raddr,
  output tts_pkg::slot_state_t     rdata
);
  import tts_pkg::*;

  slot_state_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/task_table_round_robin_scheduler.sv
// task table scheduler top level: sequencer over the slot state memory
// depends on tts_pkg and tts_slot_mem
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+----------------------------------------
//   in       | sink      | in_valid / in_stall  | action, amount, task_number
//   out      | source    | out_valid / out_stall| status, affected_count, running_valid,
//            |           |                      | running_slot, slots_used, switched
//   cfg      | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item at a time; interrupt, quiet ticks, unused codes and rejected numbers go straight
// to the result, kill and resume one read the named slot, a scan walks the filled slots (one
// memory read per slot, read data registered); create writes one slot per added task, and
// in first-come mode, unless the table filled up, a first-come dispatch scan follows;
// the result sits in an output register, so the next item is taken while it waits; a finished
// item behind a stalled output register holds in its last state and keeps the input stalled
// reset (synchronous) empties the table by zeroing the fill count; memory contents need no
// clearing pass since only filled slots are ever read; mode returns to 0, quantum to 1
`default_nettype none

module task_table_round_robin_scheduler #(
  parameter int MAX_SLOTS = 16
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire  [tts_pkg::ACTION_W-1:0]           action,
  input  wire  [tts_pkg::AMOUNT_W-1:0]           amount,
  input  wire  [tts_pkg::TASKNUM_W-1:0]          task_number,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic [tts_pkg::STATUS_W-1:0]           status,
  output logic [tts_pkg::AFFECT_W-1:0]           affected_count,
  output logic                                   running_valid,
  output logic [tts_pkg::RSLOT_W-1:0]            running_slot,
  output logic [tts_pkg::USED_W-1:0]             slots_used,
  output logic                                   switched,
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire  [tts_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire  [tts_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import tts_pkg::*;

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);

  sched_state_t state, state_next;
  scan_kind_t   kind, kind_next;

  logic [IW-1:0]       addr, addr_next;
  logic [IW-1:0]       paddr, paddr_next;
  logic [CW-1:0]       remain, remain_next;
  logic                pend, pend_next;
  logic [CW-1:0]       used, used_next;
  logic [IW-1:0]       cur, cur_next;
  logic                cur_valid, cur_valid_next;
  logic [TICK_W-1:0]   tick, tick_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [CW-1:0]       aff, aff_next;
  logic                sw, sw_next;
  logic                full, full_next;
  logic                mode;
  logic [TICK_W-1:0]   quantum;

  logic                mem_we;
  logic [IW-1:0]       mem_wa;
  slot_state_t         mem_wd;
  logic                mem_re;
  logic [IW-1:0]       mem_ra;
  slot_state_t         rd_data;

  logic                in_accept;
  logic                out_free;
  logic                num_bad;
  logic [TICK_W-1:0]   tick_inc;
  logic [TICK_W-1:0]   q_eff;
  logic                tick_fire;
  logic [CW-1:0]       room;
  logic                create_full;
  logic [CW-1:0]       create_cnt;
  logic [CW-1:0]       addr_plus;
  logic [IW-1:0]       addr_wrap;
  logic [CW-1:0]       cur_plus;
  logic [IW-1:0]       rr_start;
  logic                rd_ready;
  logic                rd_susp;
  logic                scan_hit;
  logic                scan_end;

  tts_slot_mem #(
    .DEPTH (MAX_SLOTS),
    .AW    (IW)
  ) u_slot_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .re    (mem_re),
    .raddr (mem_ra),
    .rdata (rd_data)
  );

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  assign num_bad   = (task_number == '0) || (task_number > TASKNUM_W'(used));
  assign tick_inc  = tick + 1'b1;
  assign q_eff     = (quantum == '0) ? TICK_W'(1) : quantum;
  assign tick_fire = mode && (tick_inc >= q_eff);

  assign room        = CW'(MAX_SLOTS) - used;
  assign create_full = amount > AMOUNT_W'(room);
  assign create_cnt  = create_full ? room : CW'(amount);

  // cyclic walk over the filled slots only
  assign addr_plus = CW'(addr) + 1'b1;
  assign addr_wrap = (addr_plus >= used) ? '0 : IW'(addr_plus);
  assign cur_plus  = CW'(cur) + 1'b1;
  assign rr_start  = !cur_valid ? '0 : ((cur_plus >= used) ? '0 : IW'(cur_plus));

  assign rd_ready = (rd_data == SS_READY);
  assign rd_susp  = (rd_data == SS_SUSPENDED);

  always_comb begin
    scan_hit = 1'b0;
    if (state == ST_SCAN && pend) begin
      unique case (kind)
        SK_FCFS:       scan_hit = rd_ready;
        SK_RR:         scan_hit = rd_ready || rd_susp;
        SK_KILL:       scan_hit = 1'b1;
        SK_RESUME_ONE: scan_hit = 1'b1;
        default:       scan_hit = 1'b0;
      endcase
    end
  end

  assign scan_end = (state == ST_SCAN) && !pend && (remain == '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (action)
            ACT_CREATE:     state_next = ST_CREATE;
            ACT_KILL:       state_next = num_bad ? ST_DONE : ST_SCAN;
            ACT_RESUME_ONE: state_next = num_bad ? ST_DONE : ST_SCAN;
            ACT_RESUME_ALL: state_next = ST_SCAN;
            ACT_TICK:       state_next = tick_fire ? ST_SCAN : ST_DONE;
            ACT_FCFS:       state_next = ST_SCAN;
            default:        state_next = ST_DONE;
          endcase
        end
      end
      ST_CREATE: begin
        if (remain == '0) begin
          state_next = (!full && !mode) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    kind_next       = kind;
    addr_next       = addr;
    paddr_next      = paddr;
    remain_next     = remain;
    pend_next       = pend;
    used_next       = used;
    cur_next        = cur;
    cur_valid_next  = cur_valid;
    tick_next       = tick;
    res_status_next = res_status;
    aff_next        = aff;
    sw_next         = sw;
    full_next       = full;
    mem_we          = 1'b0;
    mem_wa          = cur;
    mem_wd          = SS_SUSPENDED;
    mem_re          = 1'b0;
    mem_ra          = addr;

    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          res_status_next = STAT_DONE;
          aff_next        = '0;
          sw_next         = 1'b0;
          pend_next       = 1'b0;
          unique case (action)
            ACT_CREATE: begin
              remain_next = create_cnt;
              aff_next    = create_cnt;
              full_next   = create_full;
            end
            ACT_KILL: begin
              if (num_bad) begin
                res_status_next = STAT_NOT_FOUND;
              end else begin
                kind_next   = SK_KILL;
                addr_next   = IW'(task_number - 1'b1);
                remain_next = CW'(1);
              end
            end
            ACT_INTERRUPT: begin
              if (cur_valid) begin
                mem_we         = 1'b1;
                mem_wa         = cur;
                mem_wd         = SS_SUSPENDED;
                cur_valid_next = 1'b0;
              end
            end
            ACT_RESUME_ONE: begin
              if (num_bad) begin
                res_status_next = STAT_NOT_FOUND;
              end else begin
                kind_next   = SK_RESUME_ONE;
                addr_next   = IW'(task_number - 1'b1);
                remain_next = CW'(1);
              end
            end
            ACT_RESUME_ALL: begin
              kind_next   = SK_RESUME_ALL;
              addr_next   = '0;
              remain_next = used;
            end
            ACT_TICK: begin
              if (mode) begin
                if (tick_fire) begin
                  tick_next   = '0;
                  sw_next     = 1'b1;
                  kind_next   = SK_RR;
                  addr_next   = rr_start;
                  remain_next = used;
                  // the selected slot is always the running one, suspend it now
                  if (cur_valid) begin
                    mem_we = 1'b1;
                    mem_wa = cur;
                    mem_wd = SS_SUSPENDED;
                  end
                end else begin
                  tick_next = tick_inc;
                end
              end
            end
            ACT_FCFS: begin
              kind_next   = SK_FCFS;
              addr_next   = '0;
              remain_next = used;
            end
            default: ;
          endcase
        end
      end

      ST_CREATE: begin
        if (remain != '0) begin
          mem_we      = 1'b1;
          mem_wa      = IW'(used);
          mem_wd      = SS_READY;
          used_next   = used + 1'b1;
          remain_next = remain - 1'b1;
        end else if (full) begin
          res_status_next = STAT_FULL;
        end else if (!mode) begin
          kind_next   = SK_FCFS;
          addr_next   = '0;
          remain_next = used;
          pend_next   = 1'b0;
        end
      end

      ST_SCAN: begin
        // issue side: one read per cycle, data checked in the next cycle
        if (remain != '0) begin
          mem_re      = 1'b1;
          mem_ra      = addr;
          addr_next   = addr_wrap;
          remain_next = remain - 1'b1;
          pend_next   = 1'b1;
          paddr_next  = addr;
        end else begin
          pend_next = 1'b0;
        end

        if (pend) begin
          unique case (kind)
            SK_FCFS, SK_RR: begin
              if (scan_hit) begin
                mem_we         = 1'b1;
                mem_wa         = paddr;
                mem_wd         = SS_RUNNING;
                cur_next       = paddr;
                cur_valid_next = 1'b1;
              end
            end
            SK_RESUME_ALL: begin
              if (rd_susp) begin
                mem_we   = 1'b1;
                mem_wa   = paddr;
                mem_wd   = SS_READY;
                aff_next = aff + 1'b1;
              end
            end
            SK_KILL: begin
              if (rd_data == SS_TERMINATED) begin
                res_status_next = STAT_TERMINATED;
              end else begin
                mem_we = 1'b1;
                mem_wa = paddr;
                mem_wd = SS_TERMINATED;
                if (cur_valid && cur == paddr) begin
                  cur_valid_next = 1'b0;
                end
              end
            end
            SK_RESUME_ONE: begin
              if (rd_susp) begin
                mem_we   = 1'b1;
                mem_wa   = paddr;
                mem_wd   = SS_READY;
                aff_next = CW'(1);
              end else begin
                res_status_next = STAT_NOT_FOUND;
              end
            end
            default: ;
          endcase
        end

        if (scan_end) begin
          if (kind == SK_RR) begin
            cur_valid_next = 1'b0;
          end
          if (kind == SK_RESUME_ALL && aff == '0) begin
            res_status_next = STAT_NONE_SUSP;
          end
        end
      end

      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend      <= 1'b0;
      used      <= '0;
      cur_valid <= 1'b0;
      cur       <= '0;
      tick      <= '0;
    end else begin
      state     <= state_next;
      pend      <= pend_next;
      used      <= used_next;
      cur_valid <= cur_valid_next;
      cur       <= cur_next;
      tick      <= tick_next;
    end
  end

  always_ff @(posedge clk) begin
    kind       <= kind_next;
    addr       <= addr_next;
    paddr      <= paddr_next;
    remain     <= remain_next;
    res_status <= res_status_next;
    aff        <= aff_next;
    sw         <= sw_next;
    full       <= full_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= 1'b0;
      quantum <= TICK_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:    mode    <= cfg_data[0];
        CFG_QUANTUM: quantum <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      status         <= res_status;
      affected_count <= AFFECT_W'(aff);
      running_valid  <= cur_valid;
      running_slot   <= cur_valid ? RSLOT_W'(cur) : '0;
      slots_used     <= USED_W'(used);
      switched       <= sw;
    end
  end

endmodule

`default_nettype wire

FILE: bench/sched_result_check.sv
// result checker for the task table scheduler: tracks the slot table, predicts each result
// and compares it field by field with what the block returns; depends on tts_pkg
`timescale 1ns / 100ps

module sched_result_check #(
  parameter int SLOTS = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  input  wire                                in_stall,
  input  wire  [tts_pkg::ACTION_W-1:0]       action,
  input  wire  [tts_pkg::AMOUNT_W-1:0]       amount,
  input  wire  [tts_pkg::TASKNUM_W-1:0]      task_number,
  input  wire                                out_valid,
  input  wire                                out_stall,
  input  wire  [tts_pkg::STATUS_W-1:0]       status,
  input  wire  [tts_pkg::AFFECT_W-1:0]       affected_count,
  input  wire                                running_valid,
  input  wire  [tts_pkg::RSLOT_W-1:0]        running_slot,
  input  wire  [tts_pkg::USED_W-1:0]         slots_used,
  input  wire                                switched,
  input  wire                                cfg_valid,
  input  wire                                cfg_ready,
  input  wire  [tts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [tts_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                 pending,
  output int                                 mismatches,
  output int                                 results_checked,
  output int                                 switches_seen,
  output int                                 refusals
);
  import tts_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [AFFECT_W-1:0] affected_count;
    logic                running_valid;
    logic [RSLOT_W-1:0]  running_slot;
    logic [USED_W-1:0]   slots_used;
    logic                switched;
  } sched_result_t;

  // shadow copy of the scheduler state and its registers
  slot_state_t  slot_st [SLOTS];
  int           fill;
  bit           sel_valid;
  int           sel_slot;
  logic [7:0]   ticks;
  bit           rr_mode;
  logic [7:0]   quantum;

  sched_result_t awaited [$];

  task automatic report(input string msg);
    $display("%0t ns  sched check: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report($sformatf("result %0d %s: got %0d, expected %0d", results_checked, name,
                       got, want));
  endtask

  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) slot_st[i] = SS_TERMINATED;
    fill = 0;
    sel_valid = 0;
    sel_slot = 0;
    ticks = '0;
    rr_mode = 0;
    quantum = 8'd1;
  endfunction

  function automatic void pick_lowest_ready();
    bit hit;
    hit = 0;
    for (int i = 0; i < fill && !hit; i++) begin
      if (slot_st[i] == SS_READY) begin
        slot_st[i] = SS_RUNNING;
        sel_valid = 1;
        sel_slot = i;
        hit = 1;
      end
    end
  endfunction

  // quantum expiry: park the running task, then walk the filled slots after it
  function automatic void rotate();
    int  cursor;
    bit  hit;
    if (sel_valid && slot_st[sel_slot] == SS_RUNNING) slot_st[sel_slot] = SS_SUSPENDED;
    if (fill == 0) begin
      sel_valid = 0;
      return;
    end
    cursor = sel_valid ? (sel_slot + 1) % fill : 0;
    hit = 0;
    for (int n = 0; n < fill && !hit; n++) begin
      if (slot_st[cursor] == SS_READY || slot_st[cursor] == SS_SUSPENDED) begin
        slot_st[cursor] = SS_RUNNING;
        sel_valid = 1;
        sel_slot = cursor;
        hit = 1;
      end else begin
        cursor = (cursor + 1) % fill;
      end
    end
    if (!hit) sel_valid = 0;
  endfunction

  function automatic sched_result_t run_command(input logic [ACTION_W-1:0] act,
                                                input logic [AMOUNT_W-1:0] amt,
                                                input logic [TASKNUM_W-1:0] num);
    sched_result_t r;
    bit            full;
    r = '0;
    case (act)
      ACT_CREATE: begin
        full = 0;
        for (int i = 0; i < amt && !full; i++) begin
          if (fill >= SLOTS) begin
            full = 1;
          end else begin
            slot_st[fill] = SS_READY;
            fill++;
            r.affected_count++;
          end
        end
        if (full) r.status = STAT_FULL;
        else if (!rr_mode) pick_lowest_ready();
      end
      ACT_KILL: begin
        if (num == 0 || num > fill) begin
          r.status = STAT_NOT_FOUND;
        end else if (slot_st[num-1] == SS_TERMINATED) begin
          r.status = STAT_TERMINATED;
        end else begin
          slot_st[num-1] = SS_TERMINATED;
          if (sel_valid && sel_slot == num - 1) sel_valid = 0;
        end
      end
      ACT_INTERRUPT: begin
        if (sel_valid) begin
          slot_st[sel_slot] = SS_SUSPENDED;
          sel_valid = 0;
        end
      end
      ACT_RESUME_ONE: begin
        if (num == 0 || num > fill || slot_st[num-1] != SS_SUSPENDED) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          slot_st[num-1] = SS_READY;
          r.affected_count = AFFECT_W'(1);
        end
      end
      ACT_RESUME_ALL: begin
        for (int i = 0; i < fill; i++) begin
          if (slot_st[i] == SS_SUSPENDED) begin
            slot_st[i] = SS_READY;
            r.affected_count++;
          end
        end
        if (r.affected_count == 0) r.status = STAT_NONE_SUSP;
      end
      ACT_TICK: begin
        if (rr_mode) begin
          ticks = ticks + 8'd1;
          // a zero quantum behaves as one, which the unsigned compare gives for free
          if (ticks >= quantum) begin
            ticks = '0;
            rotate();
            r.switched = 1'b1;
          end
        end
      end
      ACT_FCFS: pick_lowest_ready();
      default: ;
    endcase
    r.running_valid = sel_valid;
    r.running_slot = sel_valid ? RSLOT_W'(sel_slot) : '0;
    r.slots_used = USED_W'(fill);
    return r;
  endfunction

  always @(posedge clk) begin : track
    sched_result_t want;
    if (rst) begin
      clear_table();
      awaited.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:    rr_mode = cfg_data[0];
          CFG_QUANTUM: quantum = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          report("result transfer with no command outstanding");
        end else begin
          want = awaited.pop_front();
          check_field("status", 8'(status), 8'(want.status));
          check_field("affected_count", 8'(affected_count), 8'(want.affected_count));
          check_field("running_valid", 8'(running_valid), 8'(want.running_valid));
          check_field("running_slot", 8'(running_slot), 8'(want.running_slot));
          check_field("slots_used", 8'(slots_used), 8'(want.slots_used));
          check_field("switched", 8'(switched), 8'(want.switched));
          results_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        want = run_command(action, amount, task_number);
        awaited.push_back(want);
        if (want.switched) switches_seen++;
        if (want.status == STAT_FULL) refusals++;
      end
      pending <= awaited.size();
    end
  end

endmodule

FILE: bench/task_table_round_robin_scheduler_tb.sv
// top of the scheduler bench: clock, reset, command and register stimulus, result stalls
// and the final verdict; depends on tts_pkg, the scheduler RTL and sched_result_check
`timescale 1ns / 100ps

module task_table_round_robin_scheduler_tb;
  import tts_pkg::*;

  localparam int SLOTS = 16;
  localparam int LONG_HOLD = 400;
  // codes the block must treat as no-ops
  localparam logic [ACTION_W-1:0]  ACT_UNUSED = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [ACTION_W-1:0]   action;
  logic [AMOUNT_W-1:0]   amount;
  logic [TASKNUM_W-1:0]  task_number;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   status;
  logic [AFFECT_W-1:0]   affected_count;
  logic                  running_valid;
  logic [RSLOT_W-1:0]    running_slot;
  logic [USED_W-1:0]     slots_used;
  logic                  switched;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int pending, mismatches, results_checked, switches_seen, refusals;
  int commands_sent;
  int holds_asked;
  bit send_fast;

  task_table_round_robin_scheduler #(.MAX_SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .amount(amount), .task_number(task_number),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .affected_count(affected_count), .running_valid(running_valid),
    .running_slot(running_slot), .slots_used(slots_used), .switched(switched),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sched_result_check #(.SLOTS(SLOTS)) u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .amount(amount), .task_number(task_number),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .affected_count(affected_count), .running_valid(running_valid),
    .running_slot(running_slot), .slots_used(slots_used), .switched(switched),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .mismatches(mismatches), .results_checked(results_checked),
    .switches_seen(switches_seen), .refusals(refusals)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("task_table_round_robin_scheduler_tb: errors");
    $finish;
  end

  // result side: random stall after each transfer, occasional long hold-off on request
  initial begin : receiver
    int  gap;
    int  holds_done;
    bit  fast;
    holds_done = 0;
    fast = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if ($urandom_range(0, 39) == 0) fast = !fast;
        if (holds_done < holds_asked) begin
          gap = LONG_HOLD;
          holds_done++;
        end else begin
          gap = fast ? 0 : $urandom_range(0, 14);
        end
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // valid is only lowered when a gap follows, so back-to-back commands keep it high
  task automatic send_cmd(input logic [ACTION_W-1:0] act, input logic [AMOUNT_W-1:0] amt,
                          input logic [TASKNUM_W-1:0] num);
    int gap;
    if ($urandom_range(0, 49) == 0) send_fast = !send_fast;
    gap = send_fast ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      action <= ACTION_W'($urandom);
      amount <= AMOUNT_W'($urandom);
      task_number <= TASKNUM_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    amount <= amt;
    task_number <= num;
    do @(posedge clk); while (in_stall);
    commands_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_cmds(input int count);
    int                   pick;
    logic [AMOUNT_W-1:0]  amt;
    logic [TASKNUM_W-1:0] num;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      amt = AMOUNT_W'($urandom);
      num = TASKNUM_W'($urandom);
      if (pick < 8) begin
        if ($urandom_range(0, 19) != 0) amt = AMOUNT_W'($urandom_range(0, 2));
        send_cmd(ACT_CREATE, amt, num);
      end else if (pick < 12) begin
        if ($urandom_range(0, 1) == 0) num = TASKNUM_W'($urandom_range(1, SLOTS));
        send_cmd(ACT_KILL, amt, num);
      end else if (pick < 24) begin
        send_cmd(ACT_INTERRUPT, amt, num);
      end else if (pick < 38) begin
        if ($urandom_range(0, 4) != 0) num = TASKNUM_W'($urandom_range(1, SLOTS));
        send_cmd(ACT_RESUME_ONE, amt, num);
      end else if (pick < 48) begin
        send_cmd(ACT_RESUME_ALL, amt, num);
      end else if (pick < 83) begin
        send_cmd(ACT_TICK, amt, num);
      end else if (pick < 95) begin
        send_cmd(ACT_FCFS, amt, num);
      end else begin
        send_cmd(ACT_UNUSED, amt, num);
      end
    end
  endtask

  initial begin : stimulus
    commands_sent = 0;
    holds_asked = 0;
    send_fast = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    action <= ACT_CREATE;
    amount <= '0;
    task_number <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MODE;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, first-come mode straight out of reset
    send_cmd(ACT_TICK, 8'd0, 8'd0);
    send_cmd(ACT_INTERRUPT, 8'd0, 8'd0);
    send_cmd(ACT_RESUME_ALL, 8'd0, 8'd0);
    send_cmd(ACT_KILL, 8'd0, 8'd0);
    send_cmd(ACT_RESUME_ONE, 8'd0, 8'd255);
    send_cmd(ACT_FCFS, 8'd0, 8'd0);
    send_cmd(ACT_CREATE, 8'd0, 8'd0);
    send_cmd(ACT_CREATE, 8'd3, 8'd0);
    // zero-size create still dispatches, leaving the earlier slot marked running
    send_cmd(ACT_CREATE, 8'd0, 8'd0);
    send_cmd(ACT_INTERRUPT, 8'd0, 8'd0);
    send_cmd(ACT_RESUME_ONE, 8'd0, 8'd2);
    send_cmd(ACT_RESUME_ONE, 8'd0, 8'd2);
    send_cmd(ACT_RESUME_ONE, 8'd0, 8'd4);
    send_cmd(ACT_FCFS, 8'd0, 8'd0);
    send_cmd(ACT_INTERRUPT, 8'd0, 8'd0);
    send_cmd(ACT_KILL, 8'd0, 8'd3);
    send_cmd(ACT_KILL, 8'd0, 8'd3);
    send_cmd(ACT_KILL, 8'd255, 8'd4);
    send_cmd(ACT_RESUME_ALL, 8'd0, 8'd0);
    send_cmd(ACT_RESUME_ALL, 8'd0, 8'd0);
    send_cmd(ACT_UNUSED, 8'd255, 8'd255);

    // round robin on a small table, then fill it past capacity
    drain_results();
    write_reg(CFG_MODE, 8'd1);
    repeat (3) send_cmd(ACT_TICK, 8'd0, 8'd0);
    send_cmd(ACT_INTERRUPT, 8'd0, 8'd0);
    send_cmd(ACT_TICK, 8'd0, 8'd0);
    send_cmd(ACT_CREATE, 8'd255, 8'd0);
    send_cmd(ACT_CREATE, 8'd1, 8'd16);
    send_cmd(ACT_TICK, 8'd0, 8'd0);

    drain_results();
    write_reg(CFG_QUANTUM, 8'd1);
    random_cmds(140);

    drain_results();
    write_reg(CFG_MODE, CFG_DATA_W'($urandom) | 8'h01);
    write_reg(CFG_QUANTUM, 8'd3);
    random_cmds(70);
    holds_asked++;
    random_cmds(80);

    drain_results();
    write_reg(CFG_MODE, CFG_DATA_W'($urandom) & 8'hFE);
    write_reg(CFG_QUANTUM, 8'd255);
    random_cmds(130);

    drain_results();
    write_reg(CFG_MODE, 8'd1);
    random_cmds(60);
    // sender pause until the block has returned everything
    drain_results();
    random_cmds(60);

    drain_results();
    write_reg(CFG_QUANTUM, 8'd0);
    random_cmds(100);

    drain_results();
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    write_reg(CFG_QUANTUM, CFG_DATA_W'($urandom_range(2, 8)));
    random_cmds(150);

    drain_results();
    write_reg(CFG_MODE, 8'd0);
    random_cmds(130);

    drain_results();
    repeat (64) @(posedge clk);
    $display("summary: %0d commands sent, %0d results checked across both modes",
             commands_sent, results_checked);
    $display("summary: %0d round robin switches, %0d creates refused on a full table",
             switches_seen, refusals);
    if (mismatches == 0) begin
      $display("task_table_round_robin_scheduler_tb: clean");
    end else begin
      $display("task_table_round_robin_scheduler_tb: errors");
    end
    $finish;
  end

endmodule
